// ===== rtl/indexed_list_insert_remove_defines.svh =====
// assertion macros for the indexed list checker
`ifndef INDEXED_LIST_INSERT_REMOVE_DEFINES_SVH
`define INDEXED_LIST_INSERT_REMOVE_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define ILIR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition in one cycle implies another in the next cycle
`define ILIR_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/ilir_pkg.sv =====
// shared types and codes of the indexed list block
`timescale 1ns / 1ps

package ilir_pkg;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_POP    = 2'd2,
    MODE_REMOVE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_UP_CHK,
    S_UP_WR,
    S_TAKE,
    S_RM_TAKE,
    S_DN_CHK,
    S_DN_WR,
    S_FIN
  } ctrl_state_e;

  typedef enum logic [1:0] {
    RD_IDX_DEC,
    RD_IDX_INC,
    RD_LAST,
    RD_POS
  } rd_sel_e;

  typedef enum logic {
    WR_SHIFT,
    WR_PUT
  } wr_sel_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_FILL,
    IDX_POS,
    IDX_DEC,
    IDX_INC
  } idx_op_e;

  typedef enum logic [1:0] {
    FILL_HOLD,
    FILL_INC,
    FILL_DEC
  } fill_op_e;

  typedef struct packed {
    logic     latch;
    logic     rd;
    rd_sel_e  rd_sel;
    logic     wr;
    wr_sel_e  wr_sel;
    idx_op_e  idx_op;
    fill_op_e fill_op;
    logic     set_res;
    status_e  res_status;
    logic     res_take;
    logic     load_out;
  } dp_cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  full;
    logic  empty;
    logic  pos_gt_fill;
    logic  pos_ge_fill;
    logic  idx_gt_pos;
    logic  idx_next_lt_fill;
    logic  out_free;
  } dp_stat_t;

endpackage

// ===== rtl/ilir_ctrl.sv =====
// controller state machine of the indexed list block
`timescale 1ns / 1ps

module ilir_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ilir_pkg::dp_stat_t stat_i,
  output ilir_pkg::dp_cmd_t  cmd_o
);
  import ilir_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECIDE;
        end
      end
      S_DECIDE: begin
        unique case (stat_i.mode)
          MODE_APPEND, MODE_INSERT: begin
            if (stat_i.full) begin
              cmd_o.set_res    = 1'b1;
              cmd_o.res_status = STAT_FULL;
              state_d          = S_FIN;
            end else if (stat_i.mode == MODE_INSERT && stat_i.pos_gt_fill) begin
              cmd_o.set_res    = 1'b1;
              cmd_o.res_status = STAT_RANGE;
              state_d          = S_FIN;
            end else begin
              cmd_o.idx_op = IDX_FILL;
              state_d      = S_UP_CHK;
            end
          end
          MODE_POP: begin
            if (stat_i.empty) begin
              cmd_o.set_res    = 1'b1;
              cmd_o.res_status = STAT_RANGE;
              state_d          = S_FIN;
            end else begin
              cmd_o.rd      = 1'b1;
              cmd_o.rd_sel  = RD_LAST;
              cmd_o.fill_op = FILL_DEC;
              state_d       = S_TAKE;
            end
          end
          MODE_REMOVE: begin
            if (stat_i.pos_ge_fill) begin
              cmd_o.set_res    = 1'b1;
              cmd_o.res_status = STAT_RANGE;
              state_d          = S_FIN;
            end else begin
              cmd_o.rd     = 1'b1;
              cmd_o.rd_sel = RD_POS;
              cmd_o.idx_op = IDX_POS;
              state_d      = S_RM_TAKE;
            end
          end
          default: state_d = S_FIN;
        endcase
      end
      S_UP_CHK: begin
        if (stat_i.idx_gt_pos) begin
          cmd_o.rd     = 1'b1;
          cmd_o.rd_sel = RD_IDX_DEC;
          state_d      = S_UP_WR;
        end else begin
          cmd_o.wr         = 1'b1;
          cmd_o.wr_sel     = WR_PUT;
          cmd_o.fill_op    = FILL_INC;
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = STAT_OK;
          state_d          = S_FIN;
        end
      end
      S_UP_WR: begin
        cmd_o.wr     = 1'b1;
        cmd_o.wr_sel = WR_SHIFT;
        cmd_o.idx_op = IDX_DEC;
        state_d      = S_UP_CHK;
      end
      S_TAKE: begin
        cmd_o.set_res    = 1'b1;
        cmd_o.res_status = STAT_OK;
        cmd_o.res_take   = 1'b1;
        state_d          = S_FIN;
      end
      S_RM_TAKE: begin
        cmd_o.set_res    = 1'b1;
        cmd_o.res_status = STAT_OK;
        cmd_o.res_take   = 1'b1;
        state_d          = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (stat_i.idx_next_lt_fill) begin
          cmd_o.rd     = 1'b1;
          cmd_o.rd_sel = RD_IDX_INC;
          state_d      = S_DN_WR;
        end else begin
          cmd_o.fill_op = FILL_DEC;
          state_d       = S_FIN;
        end
      end
      S_DN_WR: begin
        cmd_o.wr     = 1'b1;
        cmd_o.wr_sel = WR_SHIFT;
        cmd_o.idx_op = IDX_INC;
        state_d      = S_DN_CHK;
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/ilir_datapath.sv =====
// datapath of the indexed list block: entry memory, fill count, index, result registers
`timescale 1ns / 1ps

module ilir_datapath #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ilir_pkg::dp_cmd_t  cmd_i,
  output ilir_pkg::dp_stat_t stat_o,
  input  logic [1:0]         mode_i,
  input  logic signed [31:0] value_i,
  input  logic [7:0]         position_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic [1:0]         status_o,
  output logic signed [31:0] out_value_o,
  output logic [8:0]         count_o
);
  import ilir_pkg::*;

  localparam int unsigned FW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = (FW > 8) ? FW : 8;

  logic [31:0]        mem [CAPACITY];
  mode_e              mode_q;
  logic signed [31:0] val_q;
  logic [7:0]         pos_q;
  logic [FW-1:0]      fill_q;
  logic [FW-1:0]      idx_q;
  logic [31:0]        rdata_q;
  status_e            res_status_q;
  logic [31:0]        res_value_q;
  logic               out_valid_q;
  logic [1:0]         out_status_q;
  logic [31:0]        out_value_q;
  logic [8:0]         out_count_q;

  logic [FW-1:0] pos_fw;
  logic [FW-1:0] epos;
  logic [FW-1:0] idx_dec;
  logic [FW-1:0] idx_inc;
  logic [FW-1:0] last;
  logic [FW-1:0] rd_addr_fw;
  logic [FW-1:0] wr_addr_fw;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic [CW-1:0] pos_cw;
  logic [CW-1:0] fill_cw;

  assign pos_fw  = FW'(pos_q);
  assign epos    = (mode_q == MODE_APPEND) ? fill_q : pos_fw;
  assign idx_dec = idx_q - FW'(1);
  assign idx_inc = idx_q + FW'(1);
  assign last    = fill_q - FW'(1);
  assign pos_cw  = CW'(pos_q);
  assign fill_cw = CW'(fill_q);

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_IDX_DEC: rd_addr_fw = idx_dec;
      RD_IDX_INC: rd_addr_fw = idx_inc;
      RD_LAST:    rd_addr_fw = last;
      RD_POS:     rd_addr_fw = pos_fw;
      default:    rd_addr_fw = idx_q;
    endcase
  end

  always_comb begin
    unique case (cmd_i.wr_sel)
      WR_SHIFT: begin
        wr_addr_fw = idx_q;
        wr_data    = rdata_q;
      end
      WR_PUT: begin
        wr_addr_fw = epos;
        wr_data    = val_q;
      end
      default: begin
        wr_addr_fw = idx_q;
        wr_data    = rdata_q;
      end
    endcase
  end

  assign rd_addr = rd_addr_fw[AW-1:0];
  assign wr_addr = wr_addr_fw[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mode_q <= mode_e'(mode_i);
      val_q  <= value_i;
      pos_q  <= position_i;
    end
    unique case (cmd_i.idx_op)
      IDX_HOLD: idx_q <= idx_q;
      IDX_FILL: idx_q <= fill_q;
      IDX_POS:  idx_q <= pos_fw;
      IDX_DEC:  idx_q <= idx_dec;
      IDX_INC:  idx_q <= idx_inc;
      default:  idx_q <= idx_q;
    endcase
    if (cmd_i.set_res) begin
      res_status_q <= cmd_i.res_status;
      res_value_q  <= cmd_i.res_take ? rdata_q : 32'd0;
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_value_q  <= res_value_q;
      out_count_q  <= 9'(fill_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (cmd_i.fill_op)
        FILL_HOLD: fill_q <= fill_q;
        FILL_INC:  fill_q <= fill_q + FW'(1);
        FILL_DEC:  fill_q <= last;
        default:   fill_q <= fill_q;
      endcase
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    stat_o.mode             = mode_q;
    stat_o.full             = (fill_q == FW'(CAPACITY));
    stat_o.empty            = (fill_q == '0);
    stat_o.pos_gt_fill      = (pos_cw > fill_cw);
    stat_o.pos_ge_fill      = (pos_cw >= fill_cw);
    stat_o.idx_gt_pos       = (idx_q > epos);
    stat_o.idx_next_lt_fill = (idx_inc < fill_q);
    stat_o.out_free         = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign out_value_o = out_value_q;
  assign count_o     = out_count_q;

endmodule

// ===== rtl/indexed_list_insert_remove.sv =====
// top level of the indexed list block with insert and remove
//
// input channel: in_valid_i with mode_i, value_i, position_i; in_stall_o high while busy
// output channel: out_valid_o with status_o, out_value_o, count_o; out_stall_i holds it
// one request at a time; the result sits in an output register until taken
// entries moved (n): insert n = count - position, remove n = count - position - 1;
//   append, pop and error results move no entries
// the next request is taken in the cycle after the result register is loaded
// each moved entry costs a read and a write on the single-port entry memory
// reset clears the fill count and the output valid; memory contents are not cleared
// a stalled result holds the block in its final state until out_stall_i drops
`timescale 1ns / 1ps

module indexed_list_insert_remove #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic signed [31:0] value_i,
  input  logic [7:0]         position_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] out_value_o,
  output logic [8:0]         count_o
);
  import ilir_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ilir_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ilir_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .mode_i      (mode_i),
    .value_i     (value_i),
    .position_i  (position_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .status_o    (status_o),
    .out_value_o (out_value_o),
    .count_o     (count_o)
  );

endmodule

// ===== rtl/ilir_checker.sv =====
// port-level checker of the indexed list block and its bind
`timescale 1ns / 1ps
`include "indexed_list_insert_remove_defines.svh"

module ilir_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [1:0]         status_o,
  input logic signed [31:0] out_value_o,
  input logic [8:0]         count_o
);
  import ilir_pkg::*;

  logic        out_held;
  logic        status_known;
  logic        res_err;
  logic [42:0] out_word;

  assign out_held     = out_valid_o && out_stall_i;
  assign status_known = (status_o == STAT_OK) || (status_o == STAT_RANGE) ||
                        (status_o == STAT_FULL);
  assign res_err      = out_valid_o && (status_o != STAT_OK);
  assign out_word     = {status_o, out_value_o, count_o};

  // stalled result holds
  `ILIR_ASSERT_NEXT(a_out_hold, out_held, out_valid_o && $stable(out_word), "stalled result changed")

  `ILIR_ASSERT(a_status_code, !out_valid_o || status_known, "undefined status code")

  // failed request returns no value
  `ILIR_ASSERT(a_err_zero, !res_err || out_value_o == '0, "error result carries a value")

  // accepted request makes the block busy
  `ILIR_ASSERT_NEXT(a_busy, in_valid_i && !in_stall_o, in_stall_o, "request taken while busy")

endmodule

bind indexed_list_insert_remove ilir_checker u_checker (.*);

// ===== tb/sv/indexed_list_insert_remove_test.sv =====
// self-checking testbench for the indexed list block with insert and remove
`timescale 1ns / 1ps

module indexed_list_insert_remove_test;
  import ilir_pkg::*;

  localparam int unsigned LIST_CAPACITY = 256;
  localparam int unsigned CYCLE_LIMIT   = 4_000_000;
  localparam int unsigned SETTLE_CYCLES = 600;
  localparam int unsigned LONG_HOLD     = 400;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] value;
    logic [8:0]         count;
  } list_reply_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [1:0]         mode_i      = '0;
  logic signed [31:0] value_i     = '0;
  logic [7:0]         position_i  = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         status_o;
  logic signed [31:0] out_value_o;
  logic [8:0]         count_o;

  logic signed [31:0] list_q[$];
  list_reply_t        list_replies_q[$];
  int unsigned        fail_count   = 0;
  int unsigned        cycle_count  = 0;
  int unsigned        stall_left   = 0;
  int unsigned        hold_request = 0;
  bit                 idle_en      = 1'b1;

  indexed_list_insert_remove #(
    .CAPACITY(LIST_CAPACITY)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .value_i    (value_i),
    .position_i (position_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_o   (status_o),
    .out_value_o(out_value_o),
    .count_o    (count_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic int unsigned pick_idle_len();
    int unsigned r;
    if (!idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic list_reply_t apply_list_op(mode_e m, logic signed [31:0] v,
                                                logic [7:0] p);
    list_reply_t r;
    int unsigned n;
    n = list_q.size();
    r.status = STAT_OK;
    r.value  = '0;
    case (m)
      MODE_APPEND, MODE_INSERT: begin
        if (n >= LIST_CAPACITY) begin
          r.status = STAT_FULL;
        end else if (m == MODE_INSERT && p > n) begin
          r.status = STAT_RANGE;
        end else if (m == MODE_APPEND) begin
          list_q.push_back(v);
        end else begin
          list_q.insert(int'(p), v);
        end
      end
      MODE_POP: begin
        if (n == 0) begin
          r.status = STAT_RANGE;
        end else begin
          r.value = list_q.pop_back();
        end
      end
      default: begin
        if (p >= n) begin
          r.status = STAT_RANGE;
        end else begin
          r.value = list_q[p];
          list_q.delete(int'(p));
        end
      end
    endcase
    r.count = 9'(list_q.size());
    return r;
  endfunction

  task automatic send_request(input mode_e m, input logic signed [31:0] v,
                              input logic [7:0] p);
    int unsigned gap;
    gap = pick_idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= m;
    value_i    <= v;
    position_i <= p;
    do @(posedge clk_i); while (in_stall_o);
    list_replies_q.push_back(apply_list_op(m, v, p));
  endtask

  task automatic wait_all_replies();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (list_replies_q.size() != 0);
  endtask

  task automatic send_random_edit(input int unsigned grow_pct);
    int unsigned n;
    logic signed [31:0] v;
    n = list_q.size();
    v = $urandom();
    if ($urandom_range(0, 99) < 6) begin
      send_request(mode_e'($urandom_range(0, 3)), v, 8'($urandom_range(0, 255)));
    end else if ($urandom_range(0, 99) < grow_pct) begin
      if ($urandom_range(0, 1)) begin
        send_request(MODE_APPEND, v, 8'($urandom()));
      end else begin
        send_request(MODE_INSERT, v, 8'($urandom_range(0, n > 255 ? 255 : n)));
      end
    end else if (n == 0 || $urandom_range(0, 1)) begin
      send_request(MODE_POP, v, 8'($urandom()));
    end else begin
      send_request(MODE_REMOVE, v, 8'($urandom_range(0, n - 1)));
    end
  endtask

  task automatic test_empty_list();
    send_request(MODE_POP, 32'sh1234_5678, 8'd0);
    send_request(MODE_REMOVE, 32'sd0, 8'd0);
    send_request(MODE_REMOVE, 32'sd0, 8'd255);
    send_request(MODE_INSERT, 32'sd5, 8'd1);
    send_request(MODE_INSERT, 32'sd5, 8'd255);
  endtask

  task automatic test_basic_edits();
    send_request(MODE_APPEND, 32'sh7fff_ffff, 8'd255);
    send_request(MODE_APPEND, 32'sh8000_0000, 8'd0);
    send_request(MODE_INSERT, 32'sd0, 8'd0);
    send_request(MODE_INSERT, -32'sd1, 8'd3);
    send_request(MODE_INSERT, 32'sd9, 8'd5);
    send_request(MODE_INSERT, 32'sh5a5a_5a5a, 8'd2);
    send_request(MODE_REMOVE, 32'sd0, 8'd5);
    send_request(MODE_REMOVE, 32'sh7fff_ffff, 8'd2);
    send_request(MODE_REMOVE, 32'sd0, 8'd0);
    send_request(MODE_POP, -32'sd1, 8'd255);
    send_request(MODE_APPEND, 32'sd1, 8'd128);
    send_request(MODE_REMOVE, 32'sd0, 8'd255);
    send_request(MODE_POP, 32'sd0, 8'd0);
    send_request(MODE_POP, 32'sd0, 8'd0);
    send_request(MODE_POP, 32'sd0, 8'd0);
    send_request(MODE_POP, 32'sd0, 8'd0);
  endtask

  task automatic test_full_list();
    while (list_q.size() < LIST_CAPACITY) send_random_edit(100);
    send_request(MODE_APPEND, $urandom(), 8'd0);
    send_request(MODE_INSERT, $urandom(), 8'd0);
    send_request(MODE_INSERT, $urandom(), 8'd255);
    send_request(MODE_INSERT, $urandom(), 8'd200);
    send_request(MODE_REMOVE, 32'sd0, 8'd255);
    send_request(MODE_REMOVE, 32'sd0, 8'd200);
    send_request(MODE_POP, 32'sd0, 8'd0);
    while (list_q.size() > 128) send_random_edit(20);
  endtask

  task automatic test_random_edits();
    int unsigned n;
    for (int i = 0; i < 550; i++) begin
      if (i % 64 == 0) idle_en = ($urandom_range(0, 3) != 0);
      n = list_q.size();
      send_random_edit(n < 32 ? 70 : (n > 224 ? 30 : 50));
    end
    idle_en = 1'b1;
  endtask

  task automatic test_output_hold();
    hold_request = LONG_HOLD;
    repeat (12) send_random_edit(50);
  endtask

  task automatic test_sender_pause();
    repeat (15) send_random_edit(50);
    wait_all_replies();
    repeat (15) send_random_edit(50);
  endtask

  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      stall_left   = hold_request;
      hold_request = 0;
    end else if (stall_left == 0 && idle_en && $urandom_range(0, 99) < 25) begin
      stall_left = pick_idle_len();
    end
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : check_replies
    list_reply_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (list_replies_q.size() == 0) begin
        $error("reply with no request pending: status %0d value %0d count %0d",
               status_o, out_value_o, count_o);
        fail_count++;
      end else begin
        want = list_replies_q.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          fail_count++;
        end
        if (out_value_o !== want.value) begin
          $error("out_value: expected %0d, got %0d", want.value, out_value_o);
          fail_count++;
        end
        if (count_o !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, count_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL indexed_list_insert_remove");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_basic_edits();
    test_full_list();
    test_random_edits();
    test_output_hold();
    test_sender_pause();
    wait_all_replies();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS indexed_list_insert_remove");
    end else begin
      $display("FAIL indexed_list_insert_remove");
    end
    $finish;
  end

endmodule
